### hw/rtl/ucs_pkg.sv
package ucs_pkg;

    // Fixed IPv4 header, no options
    localparam int unsigned IP_HDR_BYTES = 20;
    localparam int unsigned PROTO_POS    = 9;
    localparam int unsigned ADDR_FIRST   = 12;
    localparam int unsigned UDP_HDR_MIN  = 8;
    localparam int unsigned LEN_WORD_END = 5;
    localparam int unsigned CSUM_HI_OFF  = 6;
    localparam int unsigned CSUM_LO_OFF  = 7;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // End-of-packet record handed from the accumulator to the fold stage
    typedef struct packed {
        logic [31:0] sum;
        logic [7:0]  held;
        logic        pending;
        logic        short_pkt;
    } t_fin;

endpackage

### hw/rtl/ucs_accum.sv
module ucs_accum
    import ucs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output t_fin       o_fin
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_sum, n_sum;
    logic [7:0]       r_held, n_held;
    logic [15:0]      r_seglen, n_seglen;

    logic [POS_W-1:0] off;
    logic [15:0]      eff;
    logic [15:0]      eff_n;
    logic             in_seg;
    logic [7:0]       seg_byte;
    logic [15:0]      word;
    logic [16:0]      addend;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] n_len;
    logic             end_in_hdr;

    always_comb begin
        off      = r_pos - POS_W'(IP_HDR_BYTES);
        eff      = (r_seglen < 16'(UDP_HDR_MIN)) ? 16'(UDP_HDR_MIN) : r_seglen;
        in_seg   = (r_pos >= POS_W'(IP_HDR_BYTES))
                   && ((off < POS_W'(CSUM_HI_OFF)) || (off < {1'b0, eff}));
        // checksum field counts as zero
        seg_byte = ((off == POS_W'(CSUM_HI_OFF)) || (off == POS_W'(CSUM_LO_OFF)))
                   ? 8'h00 : i_data;
        word     = {r_held, seg_byte};

        addend   = '0;
        n_held   = r_held;
        n_seglen = r_seglen;
        priority if (r_pos == POS_W'(PROTO_POS)) begin
            addend = {9'b0, i_data};
        end else if ((r_pos >= POS_W'(ADDR_FIRST)) && (r_pos < POS_W'(IP_HDR_BYTES))) begin
            if (r_pos[0]) begin
                addend = {1'b0, r_held, i_data};
            end else begin
                n_held = i_data;
            end
        end else if (in_seg) begin
            if (off[0]) begin
                if (off == POS_W'(LEN_WORD_END)) begin
                    // length goes in twice: once as data, once for the pseudo-header
                    addend   = {word, 1'b0};
                    n_seglen = word;
                end else begin
                    addend = {1'b0, word};
                end
            end else begin
                n_held = seg_byte;
            end
        end else begin
            addend = '0;
        end

        n_sum = r_sum + 32'(addend);
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);

        // Work out how the packet ended
        end_pos    = n_pos;
        end_in_hdr = (end_pos <= POS_W'(IP_HDR_BYTES));
        n_len      = end_pos - POS_W'(IP_HDR_BYTES);
        eff_n      = (n_seglen < 16'(UDP_HDR_MIN)) ? 16'(UDP_HDR_MIN) : n_seglen;

        o_fin.sum       = n_sum;
        o_fin.held      = n_held;
        o_fin.short_pkt = end_in_hdr || (n_len < POS_W'(CSUM_HI_OFF))
                          || (n_len < {1'b0, eff_n});
        priority if (end_in_hdr) begin
            o_fin.pending = (end_pos > POS_W'(ADDR_FIRST)) && end_pos[0];
        end else if (n_len < POS_W'(CSUM_HI_OFF)) begin
            o_fin.pending = n_len[0];
        end else if (n_len > {1'b0, eff_n}) begin
            o_fin.pending = eff_n[0];
        end else begin
            o_fin.pending = n_len[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_held   <= '0;
            r_seglen <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos    <= '0;
                r_sum    <= '0;
                r_held   <= '0;
                r_seglen <= '0;
            end else begin
                r_pos    <= n_pos;
                r_sum    <= n_sum;
                r_held   <= n_held;
                r_seglen <= n_seglen;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_pos == '0) && (r_sum == '0) && (r_seglen == '0))
        else $error("state not cleared after packet end");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_last && (r_pos != POS_MAX)) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("byte position did not advance");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_sum) && $stable(r_pos))
        else $error("accumulator moved without a byte");

endmodule

### hw/rtl/ucs_fold.sv
module ucs_fold
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fin_valid,
    input  t_fin        i_fin,
    output logic        o_fin_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_checksum,
    output logic        o_short
);

    logic        r_fin_valid;
    t_fin        r_fin;
    logic        r_out_valid;
    logic [15:0] r_out_csum;
    logic        r_out_short;

    logic        out_ready;
    logic [31:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        out_ready   = !r_out_valid || i_ready;
        o_fin_ready = !r_fin_valid || out_ready;
        // pad a held high byte with a zero low byte
        total = r_fin.sum + (r_fin.pending ? {16'h0, r_fin.held, 8'h00} : 32'h0);
        fold1 = {1'b0, total[31:16]} + {1'b0, total[15:0]};
        fold2 = fold1[15:0] + {15'h0, fold1[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fin_valid) begin
                r_fin_valid <= 1'b1;
            end else if (out_ready) begin
                r_fin_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid) begin
            r_fin <= i_fin;
        end
        if (out_ready && r_fin_valid) begin
            r_out_csum  <= ~fold2;
            r_out_short <= r_fin.short_pkt;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_out_csum;
    assign o_short    = r_out_short;

endmodule

### hw/rtl/udp_checksum_stream.sv
// The last byte's result passes the input, end-of-packet and output registers.
// Throughput: one byte per cycle; the pad-and-fold adder chain in the result stage sets
// the clock limit.
// Bytes keep flowing while a result waits; input stalls only if two results are backed up.
// Reset: i_rst_n, synchronous, active low; clears position, sum, held byte and length.
// After the last byte the running state clears at once, ready for the next packet.
module udp_checksum_stream
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    // result out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] checksum
    output logic [0:0]  o_m_tuser    // [0] short_packet
);

    // Input register: decouples the upstream handshake from the accumulator
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    logic       in_fire;
    logic       acc_take;
    logic       fin_ready;
    t_fin       fin;

    // A byte that closes a packet needs room in the fold stage; any other
    // byte is absorbed by the accumulator straight away.
    assign acc_take   = r_in_valid && (!r_in_last || fin_ready);
    assign o_s_tready = !r_in_valid || acc_take;
    assign in_fire    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (acc_take) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload holds whenever no new transaction lands
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Pseudo-header and segment accumulation, one byte per cycle unless a closing byte waits on the fold stage
    ucs_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (acc_take),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .o_fin   (fin)
    );

    // Pad, fold to 16 bits, invert, and hold in the output register
    ucs_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (acc_take && r_in_last),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_checksum  (o_m_tdata),
        .o_short     (o_m_tuser[0])
    );

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_mid_bytes_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> acc_take)
        else $error("non-final byte held back");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("accepted byte lost");

endmodule
